FILE: hdl/trix_pkg.sv
// Shared types and constants for the TRIX triple-average rate core.
// Holds datapath widths, the controller state and command types, and register codes.
// No dependencies.
package trix_pkg;

   localparam int SAMPLE_W   = 32;
   localparam int PERIOD_W   = 11;
   localparam int ALPHA_W    = 17;
   localparam int AVG_W      = 48;
   localparam int DIFF_W     = 49;
   localparam int LO_W       = 24;
   localparam int MUL_A_W    = 25;
   localparam int MUL_B_W    = 18;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int ACC_W      = 66;
   localparam int FRAC_SHIFT = 16;
   localparam int ROUND_HALF = 32768;
   localparam int N100_W     = 56;
   localparam int DVD_W      = 74;
   localparam int Q_W        = 33;
   localparam int REM_W      = 49;
   localparam int DIV_STEPS  = Q_W;
   localparam int CNT_W      = 6;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(14);
   localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = ALPHA_W'(8738);
   localparam logic [ALPHA_W-1:0]  ALPHA_ONE    = ALPHA_W'(65536);

   // register select is paddr bit 2
   localparam logic REG_PERIOD = 1'b0;
   localparam logic REG_ALPHA  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED,
      ST_DIFF,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_ACC,
      ST_UPDATE,
      ST_NUM,
      ST_SCALE,
      ST_DIVIDEND,
      ST_DIV_INIT,
      ST_DIV_STEP,
      ST_EMIT
   } ctrl_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SEED,
      OP_DIFF,
      OP_MUL_LO,
      OP_MUL_HI,
      OP_ACC,
      OP_UPDATE,
      OP_NUM,
      OP_SCALE,
      OP_DIVIDEND,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_EMIT
   } dp_op_type;

   typedef enum logic [1:0] {
      SEL_FIRST,
      SEL_SECOND,
      SEL_THIRD
   } avg_sel_type;

   typedef struct packed {
      dp_op_type   op;
      avg_sel_type sel;
   } dp_cmd_type;

   typedef struct packed {
      logic out_stall;
   } dp_status_type;

endpackage

FILE: hdl/trix_req_if.sv
// Input channel: one price sample word per handshake.
// Depends on trix_pkg.
interface trix_req_if;
   import trix_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       series_start;

   modport source (output valid, output sample, output series_start, input ready);
   modport sink (input valid, input sample, input series_start, output ready);

endinterface

FILE: hdl/trix_rsp_if.sv
// Result channel: one TRIX word per handshake.
// Depends on trix_pkg.
interface trix_rsp_if;
   import trix_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] trix_percent;
   logic                       divide_by_zero;

   modport source (output valid, output trix_percent, output divide_by_zero, input ready);
   modport sink (input valid, input trix_percent, input divide_by_zero, output ready);

endinterface

FILE: hdl/trix_triple_ema_rate_core.sv
// TRIX core: one sample word in, at most one percent-change word out.
// A sample that yields a result runs three average updates (difference, low and high multiply,
// accumulate, update) on the shared multiplier, then numerator, scale, dividend and divider-init
// setup, 33 restoring-divider steps and the output-word load; warm-up samples give no result word.
// The output word register lets the next sample enter while a result waits.
// Synchronous active-high reset clears averages, index, state and output valid; period 14, alpha 8738.
module trix_triple_ema_rate_core #(
   parameter int MAX_PERIOD = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   trix_req_if.sink                           req_chan,
   trix_rsp_if.source                         rsp_chan,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [trix_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [trix_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [trix_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import trix_pkg::*;

   logic [PERIOD_W-1:0] period;
   logic [ALPHA_W-1:0]  alpha;
   dp_cmd_type          cmd;
   dp_status_type       status;

   trix_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .period      (period),
      .alpha       (alpha)
   );

   trix_ctrl #(
      .MAX_PERIOD (MAX_PERIOD)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .period           (period),
      .req_valid        (req_chan.valid),
      .req_series_start (req_chan.series_start),
      .req_ready        (req_chan.ready),
      .status           (status),
      .cmd              (cmd)
   );

   trix_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .alpha              (alpha),
      .cmd                (cmd),
      .req_sample         (req_chan.sample),
      .status             (status),
      .rsp_valid          (rsp_chan.valid),
      .rsp_ready          (rsp_chan.ready),
      .rsp_trix_percent   (rsp_chan.trix_percent),
      .rsp_divide_by_zero (rsp_chan.divide_by_zero)
   );

endmodule

FILE: hdl/trix_csr.sv
// APB-style register block holding period and alpha.
// Depends on trix_pkg.
module trix_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [trix_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [trix_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [trix_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   output logic [trix_pkg::PERIOD_W-1:0]      period,
   output logic [trix_pkg::ALPHA_W-1:0]       alpha
);
   import trix_pkg::*;

   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [ALPHA_W-1:0]  alpha_ff, alpha_in;
   logic                wr_en;

   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign period     = period_ff;
   assign alpha      = alpha_ff;

   always_comb begin
      period_in  = period_ff;
      alpha_in   = alpha_ff;
      csr_prdata = '0;
      unique case (csr_paddr[2])
         REG_PERIOD: begin
            csr_prdata = CSR_DATA_W'(period_ff);
            if (wr_en) period_in = csr_pwdata[PERIOD_W-1:0];
         end
         REG_ALPHA: begin
            csr_prdata = CSR_DATA_W'(alpha_ff);
            if (wr_en) alpha_in = csr_pwdata[ALPHA_W-1:0];
         end
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
         alpha_ff  <= ALPHA_RESET;
      end else begin
         period_ff <= period_in;
         alpha_ff  <= alpha_in;
      end
   end

endmodule

FILE: hdl/trix_ctrl.sv
// Sequencer: warm-up schedule, sample index and step control for the datapath.
// Depends on trix_pkg; drives trix_dpath through dp_cmd_type.
module trix_ctrl #(
   parameter int MAX_PERIOD = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [trix_pkg::PERIOD_W-1:0] period,
   input  logic                          req_valid,
   input  logic                          req_series_start,
   output logic                          req_ready,
   input  trix_pkg::dp_status_type       status,
   output trix_pkg::dp_cmd_type          cmd
);
   import trix_pkg::*;

   localparam int IW = $clog2(3 * MAX_PERIOD + 1);
   localparam int PW = $clog2(MAX_PERIOD + 1);
   localparam logic [IW-1:0] IDX_MAX = IW'(3 * MAX_PERIOD);

   ctrl_state_type    state_ff, state_in;
   avg_sel_type       sel_ff, sel_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [2:0]        seed_ff, seed_in;
   logic [2:0]        upd_ff, upd_in;
   logic              emit_ff, emit_in;

   logic [PW-1:0]     p_eff;
   logic [IW-1:0]     i_now, t1, t2, t3;
   ctrl_state_type    after_state;
   avg_sel_type       after_sel;

   always_comb begin
      if (period == '0) begin
         p_eff = PW'(1);
      end else if (32'(period) > 32'(MAX_PERIOD)) begin
         p_eff = PW'(MAX_PERIOD);
      end else begin
         p_eff = PW'(period);
      end
      t1    = IW'(p_eff) - IW'(1);
      t2    = IW'({p_eff, 1'b0}) - IW'(2);
      t3    = IW'({p_eff, 1'b0}) + IW'(p_eff) - IW'(2);
      i_now = req_series_start ? '0 : idx_ff;
   end

   // choose the stage that follows the one just finished
   always_comb begin
      after_state = ST_IDLE;
      after_sel   = sel_ff;
      unique case (sel_ff)
         SEL_FIRST: begin
            after_sel = SEL_SECOND;
            if (seed_ff[1]) after_state = ST_SEED;
            else if (upd_ff[1]) after_state = ST_DIFF;
         end
         SEL_SECOND: begin
            after_sel = SEL_THIRD;
            if (seed_ff[2]) after_state = ST_SEED;
            else if (upd_ff[2]) after_state = ST_DIFF;
         end
         SEL_THIRD: begin
            if (emit_ff && upd_ff[2]) after_state = ST_NUM;
         end
         default: after_state = ST_IDLE;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      sel_in    = sel_ff;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      seed_in   = seed_ff;
      upd_in    = upd_ff;
      emit_in   = emit_ff;
      req_ready = 1'b0;
      cmd.op    = OP_NONE;
      cmd.sel   = sel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op  = OP_LOAD;
               idx_in  = (i_now < IDX_MAX) ? i_now + IW'(1) : i_now;
               seed_in = {i_now == t2, i_now == t1, i_now == '0};
               upd_in  = {i_now > t2, i_now > t1, i_now != '0};
               emit_in = i_now >= t3;
               sel_in  = SEL_FIRST;
               state_in = (i_now == '0) ? ST_SEED : ST_DIFF;
            end
         end
         ST_SEED: begin
            cmd.op   = OP_SEED;
            state_in = after_state;
            sel_in   = after_sel;
         end
         ST_DIFF: begin
            cmd.op   = OP_DIFF;
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            cmd.op   = OP_MUL_LO;
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.op   = OP_MUL_HI;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.op   = OP_ACC;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.op   = OP_UPDATE;
            state_in = after_state;
            sel_in   = after_sel;
         end
         ST_NUM: begin
            cmd.op   = OP_NUM;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.op   = OP_SCALE;
            state_in = ST_DIVIDEND;
         end
         ST_DIVIDEND: begin
            cmd.op   = OP_DIVIDEND;
            state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cmd.op   = OP_DIV_INIT;
            cnt_in   = '0;
            state_in = ST_DIV_STEP;
         end
         ST_DIV_STEP: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the output word slot frees up
            if (!status.out_stall) begin
               cmd.op   = OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= SEL_FIRST;
         idx_ff   <= '0;
         cnt_ff   <= '0;
         seed_ff  <= '0;
         upd_ff   <= '0;
         emit_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
         seed_ff  <= seed_in;
         upd_ff   <= upd_in;
         emit_ff  <= emit_in;
      end
   end

endmodule

FILE: hdl/trix_dpath.sv
// Datapath: three averages, shared 25x18 multiplier, restoring divider, output word register.
// Depends on trix_pkg; commanded by trix_ctrl.
module trix_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [trix_pkg::ALPHA_W-1:0]         alpha,
   input  trix_pkg::dp_cmd_type                 cmd,
   input  logic signed [trix_pkg::SAMPLE_W-1:0] req_sample,
   output trix_pkg::dp_status_type              status,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [trix_pkg::SAMPLE_W-1:0] rsp_trix_percent,
   output logic                                 rsp_divide_by_zero
);
   import trix_pkg::*;

   logic signed [AVG_W-1:0]    x_ff, x_in;
   logic signed [AVG_W-1:0]    first_ff, first_in;
   logic signed [AVG_W-1:0]    second_ff, second_in;
   logic signed [AVG_W-1:0]    third_ff, third_in;
   logic signed [AVG_W-1:0]    old_ff, old_in;
   logic signed [DIFF_W-1:0]   diff_ff, diff_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [DIFF_W-1:0]   num_ff, num_in;
   logic [AVG_W-1:0]           dabs_ff, dabs_in;
   logic                       den_neg_ff, den_neg_in;
   logic                       den_zero_ff, den_zero_in;
   logic [N100_W-1:0]          n100_ff, n100_in;
   logic                       neg_ff, neg_in;
   logic [REM_W-1:0]           d_ff, d_in;
   logic [REM_W-1:0]           rem_ff, rem_in;
   logic [Q_W-1:0]             dvd_ff, dvd_in;
   logic                       ovf_ff, ovf_in;
   logic                       out_valid_ff, out_valid_in;
   logic signed [SAMPLE_W-1:0] out_trix_ff, out_trix_in;
   logic                       out_dbz_ff, out_dbz_in;

   logic [ALPHA_W-1:0]         a_eff;
   logic signed [AVG_W-1:0]    cur, src, upd;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic [DIFF_W-1:0]          nabs;
   logic [N100_W-1:0]          nabs_w;
   logic [DVD_W-1:0]           n_total;
   logic [REM_W:0]             rem_sh;
   logic                       ge;
   logic [Q_W-1:0]             q;
   logic                       sat;

   assign a_eff = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;

   always_comb begin
      cur = first_ff;
      src = x_ff;
      unique case (cmd.sel)
         SEL_FIRST: begin
            cur = first_ff;
            src = x_ff;
         end
         SEL_SECOND: begin
            cur = second_ff;
            src = first_ff;
         end
         SEL_THIRD: begin
            cur = third_ff;
            src = second_ff;
         end
         default: begin
            cur = first_ff;
            src = x_ff;
         end
      endcase
   end

   assign mul_a   = (cmd.op == OP_MUL_HI) ? diff_ff[DIFF_W-1:LO_W] : {1'b0, diff_ff[LO_W-1:0]};
   assign mul_b   = {1'b0, a_eff};
   assign prod_in = mul_a * mul_b;
   assign upd     = cur + AVG_W'(acc_ff >>> FRAC_SHIFT);

   assign nabs    = num_ff[DIFF_W-1] ? DIFF_W'(-num_ff) : num_ff;
   assign nabs_w  = N100_W'(nabs);
   assign n_total = DVD_W'({n100_ff, 17'b0}) + DVD_W'(dabs_ff);
   assign rem_sh  = {rem_ff, dvd_ff[Q_W-1]};
   assign ge      = rem_sh >= {1'b0, d_ff};
   assign q       = dvd_ff;
   assign sat     = neg_ff ? (ovf_ff || (q > Q_W'(33'h0_8000_0000)))
                           : (ovf_ff || (q[Q_W-1:Q_W-2] != 2'b00));

   always_comb begin
      x_in         = x_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      third_in     = third_ff;
      old_in       = old_ff;
      diff_in      = diff_ff;
      acc_in       = acc_ff;
      num_in       = num_ff;
      dabs_in      = dabs_ff;
      den_neg_in   = den_neg_ff;
      den_zero_in  = den_zero_ff;
      n100_in      = n100_ff;
      neg_in       = neg_ff;
      d_in         = d_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      ovf_in       = ovf_ff;
      out_trix_in  = out_trix_ff;
      out_dbz_in   = out_dbz_ff;
      out_valid_in = out_valid_ff & ~rsp_ready;
      case (cmd.op)
         OP_LOAD: x_in = {{8{req_sample[SAMPLE_W-1]}}, req_sample, 8'b0};
         OP_SEED: begin
            if (cmd.sel == SEL_FIRST) first_in = src;
            if (cmd.sel == SEL_SECOND) second_in = src;
            if (cmd.sel == SEL_THIRD) third_in = src;
         end
         OP_DIFF: diff_in = DIFF_W'(src) - DIFF_W'(cur);
         OP_MUL_HI: acc_in = ACC_W'(prod_ff) + ACC_W'(ROUND_HALF);
         OP_ACC: acc_in = acc_ff + (ACC_W'(prod_ff) <<< LO_W);
         OP_UPDATE: begin
            if (cmd.sel == SEL_FIRST) first_in = upd;
            if (cmd.sel == SEL_SECOND) second_in = upd;
            if (cmd.sel == SEL_THIRD) begin
               third_in = upd;
               old_in   = third_ff;
            end
         end
         OP_NUM: begin
            num_in      = DIFF_W'(third_ff) - DIFF_W'(old_ff);
            den_zero_in = (third_ff == '0);
            den_neg_in  = third_ff[AVG_W-1];
            dabs_in     = third_ff[AVG_W-1] ? AVG_W'(-third_ff) : third_ff;
         end
         OP_SCALE: begin
            n100_in = (nabs_w << 6) + (nabs_w << 5) + (nabs_w << 2);
            neg_in  = num_ff[DIFF_W-1] ^ den_neg_ff;
            d_in    = {dabs_ff, 1'b0};
         end
         OP_DIVIDEND: begin
            rem_in = REM_W'(n_total[DVD_W-1:Q_W]);
            dvd_in = n_total[Q_W-1:0];
         end
         OP_DIV_INIT: ovf_in = rem_ff >= d_ff;
         OP_DIV_STEP: begin
            rem_in = ge ? REM_W'(rem_sh - {1'b0, d_ff}) : rem_sh[REM_W-1:0];
            dvd_in = {dvd_ff[Q_W-2:0], ge};
         end
         OP_EMIT: begin
            out_valid_in = 1'b1;
            out_dbz_in   = den_zero_ff;
            if (den_zero_ff) out_trix_in = '0;
            else if (neg_ff) out_trix_in = sat ? 32'h8000_0000 : (~q[SAMPLE_W-1:0]) + 32'd1;
            else out_trix_in = sat ? 32'h7FFF_FFFF : q[SAMPLE_W-1:0];
         end
         default: out_trix_in = out_trix_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= '0;
         second_ff    <= '0;
         third_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         first_ff     <= first_in;
         second_ff    <= second_in;
         third_ff     <= third_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      old_ff      <= old_in;
      diff_ff     <= diff_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      num_ff      <= num_in;
      dabs_ff     <= dabs_in;
      den_neg_ff  <= den_neg_in;
      den_zero_ff <= den_zero_in;
      n100_ff     <= n100_in;
      neg_ff      <= neg_in;
      d_ff        <= d_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      ovf_ff      <= ovf_in;
      out_trix_ff <= out_trix_in;
      out_dbz_ff  <= out_dbz_in;
   end

   assign status.out_stall   = out_valid_ff & ~rsp_ready;
   assign rsp_valid          = out_valid_ff;
   assign rsp_trix_percent   = out_trix_ff;
   assign rsp_divide_by_zero = out_dbz_ff;

endmodule

FILE: hdl/trix_checker.sv
// Port-level checks for trix_triple_ema_rate_core, bound to the top level.
// Depends on trix_pkg and the channel interfaces.
module trix_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [trix_pkg::SAMPLE_W-1:0] rsp_trix_percent,
   input logic                                 rsp_divide_by_zero
);
   import trix_pkg::*;

   a_reset_clears_valid: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_trix_percent)
                                     && $stable(rsp_divide_by_zero)))
      else $error("stalled result word changed");

   a_zero_div_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_by_zero) |-> (rsp_trix_percent == '0))
      else $error("divide by zero word with nonzero value");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("sample accepted on back-to-back cycles");

endmodule

bind trix_triple_ema_rate_core trix_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_trix_percent   (rsp_chan.trix_percent),
   .rsp_divide_by_zero (rsp_chan.divide_by_zero)
);
